[hdl/tchsf_pkg.sv]
// Shared types, constants and tables of the tricubic hexahedron shape function block.
// Holds the node selection table, the cubic basis coefficients and the result word type.
// Depends on nothing.
package tchsf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 18;
  localparam int NODE_COUNT    = 64;
  localparam int NODE_W        = 6;
  localparam int SHAPE_W       = 18;
  localparam int SHAPE_MAX     = 131071;
  localparam int SHAPE_MIN     = -131072;
  localparam int AXES          = 3;
  localparam int BASIS_N       = 4;
  localparam int BASIS_SHIFT   = 4;
  localparam int BASIS_DEPTH   = 2;
  localparam int RES_DEPTH     = 4;

  // Packed basis selection per node: x index + 4 * y index + 16 * z index.
  localparam logic [NODE_W-1:0] NODE_SEL [NODE_COUNT] = '{
    6'd0,  6'd3,  6'd15, 6'd12, 6'd48, 6'd51, 6'd63, 6'd60,
    6'd1,  6'd2,  6'd4,  6'd8,  6'd16, 6'd32, 6'd7,  6'd11,
    6'd19, 6'd35, 6'd14, 6'd13, 6'd31, 6'd47, 6'd28, 6'd44,
    6'd49, 6'd50, 6'd52, 6'd56, 6'd55, 6'd59, 6'd62, 6'd61,
    6'd5,  6'd9,  6'd10, 6'd6,  6'd17, 6'd18, 6'd34, 6'd33,
    6'd20, 6'd36, 6'd40, 6'd24, 6'd23, 6'd27, 6'd43, 6'd39,
    6'd30, 6'd29, 6'd45, 6'd46, 6'd53, 6'd54, 6'd58, 6'd57,
    6'd21, 6'd22, 6'd26, 6'd25, 6'd37, 6'd38, 6'd42, 6'd41
  };

  // Coefficients of 1, t, t^2 and t^3 for each cubic basis polynomial, times 16.
  localparam int BASIS_COEF [BASIS_N][4] = '{
    '{ -1,   1,  9,  -9 },
    '{  9, -27, -9,  27 },
    '{  9,  27, -9, -27 },
    '{ -1,  -1,  9,   9 }
  };

  typedef struct packed {
    logic [NODE_W-1:0]         node_number;
    logic signed [SHAPE_W-1:0] shape_value;
    logic                      last_node;
  } res_t;

endpackage

[hdl/tchsf_fifo.sv]
// Small first-in first-out queue of words, used between the front and back and on the output.
// Storage is a register array written in clocked logic and read combinationally. Depends on nothing.
module tchsf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNTW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNTW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[hdl/tchsf_front.sv]
// Front part: takes a coordinate triple, saturates it and forms the twelve 1-D cubic basis values.
// Six-stage pipeline with one stall for all stages. Depends on tchsf_pkg.
module tchsf_front #(
  parameter int FRAC_BITS = tchsf_pkg::FRAC_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     push_i,
  input  logic signed [tchsf_pkg::COORD_W-1:0]     coord_x_i,
  input  logic signed [tchsf_pkg::COORD_W-1:0]     coord_y_i,
  input  logic signed [tchsf_pkg::COORD_W-1:0]     coord_z_i,
  output logic                                     full_o,
  output logic                                     basis_push_o,
  output logic [tchsf_pkg::AXES*tchsf_pkg::BASIS_N*(FRAC_BITS+2)-1:0] basis_o,
  input  logic                                     basis_full_i
);

  localparam int TW  = FRAC_BITS + 2;
  localparam int PW  = 2 * TW;
  localparam int SW  = TW + 7;
  localparam int CW  = (TW > tchsf_pkg::COORD_W) ? TW : tchsf_pkg::COORD_W;
  localparam int NL  = tchsf_pkg::AXES * tchsf_pkg::BASIS_N;
  localparam int NST = 6;
  localparam logic signed [CW-1:0] ONE_C  = CW'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [PW-1:0] HALF_P = PW'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [SW-1:0] HALF_S = SW'(64'sd1 <<< (tchsf_pkg::BASIS_SHIFT - 1));

  function automatic logic signed [TW-1:0] round_p(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    r = v + HALF_P - PW'(v[PW-1]);
    return TW'(r >>> FRAC_BITS);
  endfunction

  logic [NST-1:0] v_q, v_d;
  logic           en;

  logic signed [tchsf_pkg::COORD_W-1:0] coord_in [tchsf_pkg::AXES];
  logic signed [TW-1:0] sat_t [tchsf_pkg::AXES];
  logic signed [TW-1:0] a_t_q  [tchsf_pkg::AXES];
  logic signed [TW-1:0] b_t_q  [tchsf_pkg::AXES];
  logic signed [PW-1:0] b_sq_q [tchsf_pkg::AXES];
  logic signed [TW-1:0] c_t_q  [tchsf_pkg::AXES];
  logic signed [TW-1:0] c_t2_q [tchsf_pkg::AXES];
  logic signed [TW-1:0] d_t_q  [tchsf_pkg::AXES];
  logic signed [TW-1:0] d_t2_q [tchsf_pkg::AXES];
  logic signed [PW-1:0] d_cu_q [tchsf_pkg::AXES];
  logic signed [TW-1:0] e_t_q  [tchsf_pkg::AXES];
  logic signed [TW-1:0] e_t2_q [tchsf_pkg::AXES];
  logic signed [TW-1:0] e_t3_q [tchsf_pkg::AXES];
  logic signed [TW-1:0] l_d [NL];
  logic signed [TW-1:0] l_q [NL];

  assign coord_in[0] = coord_x_i;
  assign coord_in[1] = coord_y_i;
  assign coord_in[2] = coord_z_i;

  assign en           = ~v_q[NST-1] | ~basis_full_i;
  assign full_o       = ~en;
  assign basis_push_o = v_q[NST-1] & ~basis_full_i;
  assign v_d          = {v_q[NST-2:0], push_i};

  always_comb begin
    logic signed [CW-1:0] ext;
    for (int ax = 0; ax < tchsf_pkg::AXES; ax++) begin
      ext = CW'(coord_in[ax]);
      if (ext > ONE_C) begin
        ext = ONE_C;
      end else if (ext < -ONE_C) begin
        ext = -ONE_C;
      end
      sat_t[ax] = TW'(ext);
    end
  end

  always_comb begin
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] r;
    for (int ax = 0; ax < tchsf_pkg::AXES; ax++) begin
      for (int i = 0; i < tchsf_pkg::BASIS_N; i++) begin
        s = (SW'(tchsf_pkg::BASIS_COEF[i][0]) <<< FRAC_BITS)
          + SW'(tchsf_pkg::BASIS_COEF[i][1]) * SW'(e_t_q[ax])
          + SW'(tchsf_pkg::BASIS_COEF[i][2]) * SW'(e_t2_q[ax])
          + SW'(tchsf_pkg::BASIS_COEF[i][3]) * SW'(e_t3_q[ax]);
        r = s + HALF_S - SW'(s[SW-1]);
        l_d[ax*tchsf_pkg::BASIS_N+i] = TW'(r >>> tchsf_pkg::BASIS_SHIFT);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int ax = 0; ax < tchsf_pkg::AXES; ax++) begin
        a_t_q[ax]  <= sat_t[ax];
        b_t_q[ax]  <= a_t_q[ax];
        b_sq_q[ax] <= a_t_q[ax] * a_t_q[ax];
        c_t_q[ax]  <= b_t_q[ax];
        c_t2_q[ax] <= round_p(b_sq_q[ax]);
        d_t_q[ax]  <= c_t_q[ax];
        d_t2_q[ax] <= c_t2_q[ax];
        d_cu_q[ax] <= c_t2_q[ax] * c_t_q[ax];
        e_t_q[ax]  <= d_t_q[ax];
        e_t2_q[ax] <= d_t2_q[ax];
        e_t3_q[ax] <= round_p(d_cu_q[ax]);
      end
      for (int n = 0; n < NL; n++) begin
        l_q[n] <= l_d[n];
      end
    end
  end

  always_comb begin
    for (int n = 0; n < NL; n++) begin
      basis_o[n*TW +: TW] = l_q[n];
    end
  end

endmodule

[hdl/tchsf_back.sv]
// Back part: walks the 64 nodes of one basis set and forms each triple product with rounding.
// Four-stage multiply pipeline with one stall for all stages. Depends on tchsf_pkg.
module tchsf_back #(
  parameter int FRAC_BITS = tchsf_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [tchsf_pkg::AXES*tchsf_pkg::BASIS_N*(FRAC_BITS+2)-1:0] basis_i,
  input  logic                  basis_empty_i,
  output logic                  basis_pop_o,
  output logic                  res_push_o,
  output tchsf_pkg::res_t       res_o,
  input  logic                  res_full_i
);

  localparam int TW  = FRAC_BITS + 2;
  localparam int PW  = 2 * TW;
  localparam int XW  = (TW > tchsf_pkg::SHAPE_W) ? TW : tchsf_pkg::SHAPE_W;
  localparam int NW  = tchsf_pkg::NODE_W;
  localparam int BN  = tchsf_pkg::BASIS_N;
  localparam int NST = 4;
  localparam logic signed [PW-1:0] HALF_P = PW'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [XW-1:0] SMAX_X = XW'(tchsf_pkg::SHAPE_MAX);
  localparam logic signed [XW-1:0] SMIN_X = XW'(tchsf_pkg::SHAPE_MIN);

  function automatic logic signed [TW-1:0] round_p(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    r = v + HALF_P - PW'(v[PW-1]);
    return TW'(r >>> FRAC_BITS);
  endfunction

  logic [NST-1:0] v_q, v_d;
  logic           en, issue, node_last;
  logic [NW-1:0]  node_q, node_d, sel;

  logic signed [TW-1:0] lx_arr [BN];
  logic signed [TW-1:0] ly_arr [BN];
  logic signed [TW-1:0] lz_arr [BN];

  logic signed [PW-1:0] s1_prod_q;
  logic signed [TW-1:0] s1_lz_q;
  logic [NW-1:0]        s1_node_q;
  logic                 s1_last_q;
  logic signed [TW-1:0] s2_p_q;
  logic signed [TW-1:0] s2_lz_q;
  logic [NW-1:0]        s2_node_q;
  logic                 s2_last_q;
  logic signed [PW-1:0] s3_prod_q;
  logic [NW-1:0]        s3_node_q;
  logic                 s3_last_q;
  tchsf_pkg::res_t      res_d, res_q;

  always_comb begin
    for (int i = 0; i < BN; i++) begin
      lx_arr[i] = basis_i[(0*BN+i)*TW +: TW];
      ly_arr[i] = basis_i[(1*BN+i)*TW +: TW];
      lz_arr[i] = basis_i[(2*BN+i)*TW +: TW];
    end
  end

  assign en          = ~v_q[NST-1] | ~res_full_i;
  assign issue       = en & ~basis_empty_i;
  assign node_last   = (node_q == NW'(tchsf_pkg::NODE_COUNT - 1));
  assign basis_pop_o = issue & node_last;
  assign res_push_o  = v_q[NST-1] & ~res_full_i;
  assign res_o       = res_q;
  assign sel         = tchsf_pkg::NODE_SEL[node_q];
  assign v_d         = {v_q[NST-2:0], issue};
  assign node_d      = issue ? (node_last ? '0 : node_q + NW'(1)) : node_q;

  always_comb begin
    logic signed [XW-1:0] vx;
    vx = XW'(round_p(s3_prod_q));
    if (vx > SMAX_X) begin
      vx = SMAX_X;
    end else if (vx < SMIN_X) begin
      vx = SMIN_X;
    end
    res_d.node_number = s3_node_q;
    res_d.shape_value = tchsf_pkg::SHAPE_W'(vx);
    res_d.last_node   = s3_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      node_q <= '0;
    end else begin
      node_q <= node_d;
      if (en) begin
        v_q <= v_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_prod_q <= lx_arr[sel[1:0]] * ly_arr[sel[3:2]];
      s1_lz_q   <= lz_arr[sel[5:4]];
      s1_node_q <= node_q;
      s1_last_q <= node_last;
      s2_p_q    <= round_p(s1_prod_q);
      s2_lz_q   <= s1_lz_q;
      s2_node_q <= s1_node_q;
      s2_last_q <= s1_last_q;
      s3_prod_q <= s2_p_q * s2_lz_q;
      s3_node_q <= s2_node_q;
      s3_last_q <= s2_last_q;
      res_q     <= res_d;
    end
  end

endmodule

[hdl/tricubic_hex_shape_functions.sv]
// Top level of the tricubic 64-node hexahedron shape function block.
// Connects the front, the basis queue, the back and the result queue.
// Depends on tchsf_pkg, tchsf_front, tchsf_back and tchsf_fifo.
//
//   channel  | handshake         | words
//   ---------+-------------------+-----------------------------------------------
//   input    | push / full       | coord_x_i, coord_y_i, coord_z_i
//   result   | empty / pop       | node_number_o, shape_value_o, last_node_o
//
// Each input word yields 64 result words, one per cycle while the result queue has room;
// the back's node counter walks them. The first result reaches the result ports through
// the front's stages, the basis queue, the back's stages and the result queue.
// Reset clears all control state; no memory needs a clearing pass.
// Either side may stall at any time; the basis queue lets the front take the next word
// while the back is still walking the nodes of the previous one.
module tricubic_hex_shape_functions #(
  parameter int FRAC_BITS   = tchsf_pkg::FRAC_BITS_DEF,
  parameter int BASIS_DEPTH = tchsf_pkg::BASIS_DEPTH,
  parameter int RES_DEPTH   = tchsf_pkg::RES_DEPTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [tchsf_pkg::COORD_W-1:0]  coord_x_i,
  input  logic signed [tchsf_pkg::COORD_W-1:0]  coord_y_i,
  input  logic signed [tchsf_pkg::COORD_W-1:0]  coord_z_i,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [tchsf_pkg::NODE_W-1:0]          node_number_o,
  output logic signed [tchsf_pkg::SHAPE_W-1:0]  shape_value_o,
  output logic                                  last_node_o
);

  localparam int BW = tchsf_pkg::AXES * tchsf_pkg::BASIS_N * (FRAC_BITS + 2);
  localparam int RW = $bits(tchsf_pkg::res_t);

  logic            basis_push, basis_full, basis_pop, basis_empty;
  logic [BW-1:0]   basis_in, basis_out;
  logic            res_push, res_full;
  tchsf_pkg::res_t res_in, res_out;
  logic [RW-1:0]   res_word;

  tchsf_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .coord_z_i    (coord_z_i),
    .full_o       (full),
    .basis_push_o (basis_push),
    .basis_o      (basis_in),
    .basis_full_i (basis_full)
  );

  tchsf_fifo #(
    .WIDTH (BW),
    .DEPTH (BASIS_DEPTH)
  ) u_basis_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (basis_push),
    .data_i  (basis_in),
    .full_o  (basis_full),
    .pop_i   (basis_pop),
    .data_o  (basis_out),
    .empty_o (basis_empty)
  );

  tchsf_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .basis_i       (basis_out),
    .basis_empty_i (basis_empty),
    .basis_pop_o   (basis_pop),
    .res_push_o    (res_push),
    .res_o         (res_in),
    .res_full_i    (res_full)
  );

  tchsf_fifo #(
    .WIDTH (RW),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (RW'(res_in)),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_word),
    .empty_o (empty)
  );

  assign res_out       = tchsf_pkg::res_t'(res_word);
  assign node_number_o = res_out.node_number;
  assign shape_value_o = res_out.shape_value;
  assign last_node_o   = res_out.last_node;

endmodule
